@@ src/thick_line_rasterizer_macros.svh @@
// ----------------------------------------------------------------------------
// Thick line rasterizer assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef THICK_LINE_RASTERIZER_MACROS_SVH
`define THICK_LINE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TLR_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thick_line_rasterizer: same-cycle check failed");

// next-cycle implication
`define TLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thick_line_rasterizer: next-cycle check failed");

`else

`define TLR_ASSERT_HOLDS(label, clk, rst_n, ante, cons)

`define TLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/tlr_pkg.sv @@
// ----------------------------------------------------------------------------
// Thick line rasterizer package
// Shared codes, request queue entry and clip configuration types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlr_pkg;

    typedef enum logic
    {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    typedef enum logic [0:0]
    {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [12:0] IMAGE_DIM_RESET = 13'd256;

    typedef struct packed
    {
        logic               is_step;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               dir_x_neg;
        logic               dir_y_neg;
        logic [16:0]        abs_dx;
        logic signed [16:0] neg_abs_dy;
        logic [2:0]         brush_radius;
        logic [31:0]        line_color;
    } line_cmd_t;

    typedef struct packed
    {
        logic [12:0] image_width;
        logic [12:0] image_height;
    } clip_cfg_t;

    function automatic logic [5:0] square3(input logic [2:0] a);
        return {3'b000, a} * {3'b000, a};
    endfunction

endpackage

@@ src/tlr_req_if.sv @@
// ----------------------------------------------------------------------------
// Thick line rasterizer request channel
// Start and step requests with their line parameters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlr_req_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [3:0]         brush_thickness;
    logic [31:0]        draw_color;

    modport source
    (
        output valid, action, start_x, start_y, end_x, end_y, brush_thickness, draw_color,
        input  ready
    );

    modport sink
    (
        input  valid, action, start_x, start_y, end_x, end_y, brush_thickness, draw_color,
        output ready
    );
endinterface

@@ src/tlr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Thick line rasterizer pixel channel
// One candidate pixel per step request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlr_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_color;
    logic        write_enable;
    logic        line_done;
    logic        no_line;

    modport source
    (
        output valid, pixel_x, pixel_y, pixel_color, write_enable, line_done, no_line,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_x, pixel_y, pixel_color, write_enable, line_done, no_line,
        output ready
    );
endinterface

@@ src/tlr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Thick line rasterizer configuration channel
// Register index and write data for the clip registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tlr_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [12:0] data;

    modport source
    (
        output valid, index, data,
        input  ready
    );

    modport sink
    (
        input  valid, index, data,
        output ready
    );
endinterface

@@ src/tlr_front.sv @@
// ----------------------------------------------------------------------------
// Thick line rasterizer front end
// Accepts requests, classifies start or step and precomputes line setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlr_front #(
    parameter int MAX_THICKNESS = 15
) (
    tlr_req_if.sink          req,
    input  logic             queue_full,
    output logic             push,
    output tlr_pkg::line_cmd_t push_cmd
);

    localparam logic [4:0] THICK_LIMIT = 5'(MAX_THICKNESS);

    logic signed [16:0] delta_x;
    logic signed [16:0] delta_y;
    logic [4:0]         thick_ext;
    logic [4:0]         thick_sat;

    assign req.ready = !queue_full;
    assign push      = req.valid && !queue_full;

    always_comb
    begin
        delta_x   = 17'(req.end_x) - 17'(req.start_x);
        delta_y   = 17'(req.end_y) - 17'(req.start_y);
        thick_ext = {1'b0, req.brush_thickness};
        thick_sat = (thick_ext > THICK_LIMIT) ? THICK_LIMIT : thick_ext;

        push_cmd.is_step      = (req.action == tlr_pkg::ACT_STEP);
        push_cmd.start_x      = req.start_x;
        push_cmd.start_y      = req.start_y;
        push_cmd.end_x        = req.end_x;
        push_cmd.end_y        = req.end_y;
        push_cmd.dir_x_neg    = !(req.start_x < req.end_x);
        push_cmd.dir_y_neg    = !(req.start_y < req.end_y);
        push_cmd.abs_dx       = delta_x[16] ? 17'(-delta_x) : 17'(delta_x);
        push_cmd.neg_abs_dy   = delta_y[16] ? delta_y : -delta_y;
        push_cmd.brush_radius = thick_sat[3:1];
        push_cmd.line_color   = req.draw_color;
    end

endmodule

@@ src/tlr_queue.sv @@
// ----------------------------------------------------------------------------
// Thick line rasterizer request queue
// Two-entry FIFO between the front end and the raster engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlr_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  tlr_pkg::line_cmd_t                  push_cmd,
    input  logic                                pop,
    output logic                                full,
    output logic                                head_valid,
    output tlr_pkg::line_cmd_t                  head_cmd,
    output logic [tlr_pkg::QUEUE_CNT_W-1:0]     level
);

    tlr_pkg::line_cmd_t                 entry_reg [tlr_pkg::QUEUE_DEPTH];
    logic [tlr_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [tlr_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [tlr_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [tlr_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [tlr_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [tlr_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic                               do_pop;

    assign full       = (count_reg == tlr_pkg::QUEUE_CNT_W'(tlr_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign level      = count_reg;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/tlr_back.sv @@
// ----------------------------------------------------------------------------
// Thick line rasterizer raster engine
// Walks the Bresenham line and brush square, one candidate pixel per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlr_back #(
    parameter int MAX_DIM = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  tlr_pkg::line_cmd_t   head_cmd,
    input  tlr_pkg::clip_cfg_t   clip_cfg,
    output logic                 pop,
    tlr_rsp_if.source            rsp
);

    localparam logic [16:0] DIM_LIMIT = 17'(MAX_DIM);

    logic signed [15:0] cur_x_reg,  cur_x_next;
    logic signed [15:0] cur_y_reg,  cur_y_next;
    logic signed [15:0] stop_x_reg, stop_x_next;
    logic signed [15:0] stop_y_reg, stop_y_next;
    logic               dir_x_neg_reg, dir_x_neg_next;
    logic               dir_y_neg_reg, dir_y_neg_next;
    logic [16:0]        abs_dx_reg, abs_dx_next;
    logic signed [16:0] neg_abs_dy_reg, neg_abs_dy_next;
    logic signed [17:0] error_reg, error_next;
    logic [2:0]         radius_reg, radius_next;
    logic [3:0]         offset_x_reg, offset_x_next;
    logic [3:0]         offset_y_reg, offset_y_next;
    logic [31:0]        color_reg, color_next;
    logic               active_reg, active_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [11:0]        pixel_x_reg, pixel_x_next;
    logic [11:0]        pixel_y_reg, pixel_y_next;
    logic [31:0]        pixel_color_reg, pixel_color_next;
    logic               write_enable_reg, write_enable_next;
    logic               line_done_reg, line_done_next;
    logic               no_line_reg, no_line_next;

    logic [3:0]         radius_ext;
    logic [3:0]         diam;
    logic [3:0]         mag_x;
    logic [3:0]         mag_y;
    logic signed [16:0] off_dx;
    logic signed [16:0] off_dy;
    logic signed [16:0] fx;
    logic signed [16:0] fy;
    logic [6:0]         dist_sq;
    logic [6:0]         radius_sq;
    logic [16:0]        lim_w;
    logic [16:0]        lim_h;
    logic               in_disk;
    logic               in_image;
    logic               pix_we;
    logic               last_x;
    logic               last_y;
    logic               at_end;
    logic signed [18:0] e2;
    logic               move_x;
    logic               move_y;
    logic signed [18:0] err_sum;

    assign pop             = head_valid && (!rsp_valid_reg || rsp.ready);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.pixel_x      = pixel_x_reg;
    assign rsp.pixel_y      = pixel_y_reg;
    assign rsp.pixel_color  = pixel_color_reg;
    assign rsp.write_enable = write_enable_reg;
    assign rsp.line_done    = line_done_reg;
    assign rsp.no_line      = no_line_reg;

    always_comb
    begin
        radius_ext = {1'b0, radius_reg};
        diam       = {radius_reg, 1'b0};
        mag_x      = (offset_x_reg >= radius_ext) ? offset_x_reg - radius_ext
                                                  : radius_ext - offset_x_reg;
        mag_y      = (offset_y_reg >= radius_ext) ? offset_y_reg - radius_ext
                                                  : radius_ext - offset_y_reg;
        off_dx     = 17'({1'b0, offset_x_reg}) - 17'({1'b0, radius_ext});
        off_dy     = 17'({1'b0, offset_y_reg}) - 17'({1'b0, radius_ext});
        fx         = 17'(cur_x_reg) + off_dx;
        fy         = 17'(cur_y_reg) + off_dy;
        dist_sq    = 7'(tlr_pkg::square3(mag_x[2:0])) + 7'(tlr_pkg::square3(mag_y[2:0]));
        radius_sq  = 7'(tlr_pkg::square3(radius_reg));
        in_disk    = (dist_sq <= radius_sq);
        lim_w      = ({4'b0000, clip_cfg.image_width} > DIM_LIMIT)
                     ? DIM_LIMIT : {4'b0000, clip_cfg.image_width};
        lim_h      = ({4'b0000, clip_cfg.image_height} > DIM_LIMIT)
                     ? DIM_LIMIT : {4'b0000, clip_cfg.image_height};
        in_image   = !fx[16] && !fy[16]
                     && ({1'b0, fx[15:0]} < lim_w) && ({1'b0, fy[15:0]} < lim_h);
        pix_we     = in_disk && in_image;
        last_x     = (offset_x_reg == diam);
        last_y     = (offset_y_reg == diam);
        at_end     = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
        e2         = 19'(error_reg) <<< 1;
        move_x     = (e2 >= 19'(neg_abs_dy_reg));
        move_y     = (e2 <= $signed({2'b00, abs_dx_reg}));
        err_sum    = 19'(error_reg)
                     + (move_x ? 19'(neg_abs_dy_reg) : 19'sd0)
                     + (move_y ? $signed({2'b00, abs_dx_reg}) : 19'sd0);

        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        stop_x_next     = stop_x_reg;
        stop_y_next     = stop_y_reg;
        dir_x_neg_next  = dir_x_neg_reg;
        dir_y_neg_next  = dir_y_neg_reg;
        abs_dx_next     = abs_dx_reg;
        neg_abs_dy_next = neg_abs_dy_reg;
        error_next      = error_reg;
        radius_next     = radius_reg;
        offset_x_next   = offset_x_reg;
        offset_y_next   = offset_y_reg;
        color_next      = color_reg;
        active_next     = active_reg;

        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        pixel_color_next  = pixel_color_reg;
        write_enable_next = write_enable_reg;
        line_done_next    = line_done_reg;
        no_line_next      = no_line_reg;

        if (pop)
        begin
            if (!head_cmd.is_step)
            begin
                cur_x_next      = head_cmd.start_x;
                cur_y_next      = head_cmd.start_y;
                stop_x_next     = head_cmd.end_x;
                stop_y_next     = head_cmd.end_y;
                dir_x_neg_next  = head_cmd.dir_x_neg;
                dir_y_neg_next  = head_cmd.dir_y_neg;
                abs_dx_next     = head_cmd.abs_dx;
                neg_abs_dy_next = head_cmd.neg_abs_dy;
                error_next      = $signed({1'b0, head_cmd.abs_dx}) + 18'(head_cmd.neg_abs_dy);
                radius_next     = head_cmd.brush_radius;
                offset_x_next   = '0;
                offset_y_next   = '0;
                color_next      = head_cmd.line_color;
                active_next     = 1'b1;
                rsp_valid_next  = 1'b0;
            end
            else if (!active_reg)
            begin
                rsp_valid_next    = 1'b1;
                pixel_x_next      = '0;
                pixel_y_next      = '0;
                pixel_color_next  = '0;
                write_enable_next = 1'b0;
                line_done_next    = 1'b0;
                no_line_next      = 1'b1;
            end
            else
            begin
                rsp_valid_next    = 1'b1;
                pixel_x_next      = pix_we ? fx[11:0] : 12'd0;
                pixel_y_next      = pix_we ? fy[11:0] : 12'd0;
                pixel_color_next  = color_reg;
                write_enable_next = pix_we;
                line_done_next    = last_x && last_y && at_end;
                no_line_next      = 1'b0;

                offset_x_next = last_x ? 4'd0 : offset_x_reg + 4'd1;
                if (last_x)
                begin
                    offset_y_next = last_y ? 4'd0 : offset_y_reg + 4'd1;
                    if (last_y)
                    begin
                        if (at_end)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            error_next = err_sum[17:0];
                            if (move_x)
                            begin
                                cur_x_next = dir_x_neg_reg ? cur_x_reg - 16'sd1
                                                           : cur_x_reg + 16'sd1;
                            end
                            if (move_y)
                            begin
                                cur_y_next = dir_y_neg_reg ? cur_y_reg - 16'sd1
                                                           : cur_y_reg + 16'sd1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
            offset_x_reg  <= offset_x_next;
            offset_y_reg  <= offset_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg        <= cur_x_next;
        cur_y_reg        <= cur_y_next;
        stop_x_reg       <= stop_x_next;
        stop_y_reg       <= stop_y_next;
        dir_x_neg_reg    <= dir_x_neg_next;
        dir_y_neg_reg    <= dir_y_neg_next;
        abs_dx_reg       <= abs_dx_next;
        neg_abs_dy_reg   <= neg_abs_dy_next;
        error_reg        <= error_next;
        radius_reg       <= radius_next;
        color_reg        <= color_next;
        pixel_x_reg      <= pixel_x_next;
        pixel_y_reg      <= pixel_y_next;
        pixel_color_reg  <= pixel_color_next;
        write_enable_reg <= write_enable_next;
        line_done_reg    <= line_done_next;
        no_line_reg      <= no_line_next;
    end

endmodule

@@ src/thick_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// Thick line rasterizer
// Bresenham line walker with a disk brush and image clipping.
// ----------------------------------------------------------------------------
// A start request loads a line and produces no pixel; every step request
// produces exactly one candidate pixel. Requests are taken one per clock
// whenever the two-entry queue has room, and the raster engine retires one
// queued request per clock while the pixel output register is free or being
// read, so a stream of steps sustains one pixel per cycle. A step passes
// through the queue entry register and then the pixel output register. Each
// pixel costs one brush offset update, or one Bresenham advance at the end of
// a brush sweep, in the raster engine. Configuration writes are accepted every
// cycle and must only be issued while no request is outstanding.
`timescale 1ns / 1ps

`include "thick_line_rasterizer_macros.svh"

module thick_line_rasterizer #(
    parameter int MAX_DIM       = 4096,
    parameter int MAX_THICKNESS = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    tlr_req_if.sink    req,
    tlr_rsp_if.source  rsp,
    tlr_cfg_if.sink    cfg
);

    tlr_pkg::line_cmd_t                 push_cmd;
    tlr_pkg::line_cmd_t                 head_cmd;
    tlr_pkg::clip_cfg_t                 clip_cfg;
    logic                               push;
    logic                               pop;
    logic                               queue_full;
    logic                               head_valid;
    logic [tlr_pkg::QUEUE_CNT_W-1:0]    q_level;
    logic [12:0]                        width_reg, width_next;
    logic [12:0]                        height_reg, height_next;

    assign cfg.ready             = 1'b1;
    assign clip_cfg.image_width  = width_reg;
    assign clip_cfg.image_height = height_reg;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                tlr_pkg::CFG_IMAGE_WIDTH:  width_next  = cfg.data;
                tlr_pkg::CFG_IMAGE_HEIGHT: height_next = cfg.data;
                default:                   width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tlr_pkg::IMAGE_DIM_RESET;
            height_reg <= tlr_pkg::IMAGE_DIM_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    tlr_front #(
        .MAX_THICKNESS (MAX_THICKNESS)
    ) u_front (
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    tlr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .level      (q_level)
    );

    tlr_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .clip_cfg   (clip_cfg),
        .pop        (pop),
        .rsp        (rsp)
    );

    `TLR_ASSERT_HOLDS(a_queue_bound, clk, rst_n, 1'b1, q_level <= tlr_pkg::QUEUE_CNT_W'(tlr_pkg::QUEUE_DEPTH))
    `TLR_ASSERT_HOLDS(a_full_stalls, clk, rst_n, queue_full, !req.ready)
    `TLR_ASSERT_HOLDS(a_no_line_clean, clk, rst_n, rsp.valid && rsp.no_line, !rsp.write_enable && !rsp.line_done && (rsp.pixel_color == 32'd0))
    `TLR_ASSERT_NEXT(a_queue_fill, clk, rst_n, push && !pop, q_level == $past(q_level) + 2'd1)

endmodule
